### src/dsa_pkg.sv
// Shared types and constants for the descriptor slot allocator.
// Holds field widths, codes and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package dsa_pkg;

    // Field widths fixed by the item format
    localparam int ACTION_W  = 2;
    localparam int HEAP_W    = 2;
    localparam int COUNT_W   = 13;
    localparam int OFFSET_W  = 22;
    localparam int SIZE_W    = 11;
    localparam int SLOT_W    = 12;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_HEAPS = 4;

    // Two quotient bits per divider cycle
    localparam int DIV_ITER = OFFSET_W / 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_RESOURCE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_SAMPLER  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_TARGET   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DEPTH    = CFG_IDX_W'(3);

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_RANGE = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [HEAP_W-1:0] {
        HEAP_RESOURCE = 2'd0,
        HEAP_SAMPLER  = 2'd1,
        HEAP_TARGET   = 2'd2,
        HEAP_DEPTH    = 2'd3
    } t_heap;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EXHAUSTED  = 2'd1,
        ST_NOT_SHADER = 2'd2,
        ST_BAD_FREE   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_DIV,
        S_MUL,
        S_RESULT
    } t_state;

    typedef struct packed {
        t_action              action;
        t_heap                heap_type;
        logic [COUNT_W-1:0]   range_count;
        logic [OFFSET_W-1:0]  slot_offset;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [OFFSET_W-1:0]  offset_out;
        logic [SLOT_W-1:0]    slot_index;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic    load;        // capture accepted item
        logic    pop;         // read top of free stack, drop depth
        logic    bump_one;    // index from bump pointer, advance by one
        logic    bump_range;  // index from bump pointer, advance by count
        logic    take_read;   // index from stack read data
        logic    div_start;   // start offset / size
        logic    push;        // push quotient onto free stack
        logic    mult;        // offset = index * size
        logic    fail;        // failed item: zero offset and index
        t_status fail_code;
        logic    out_load;    // move result into output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_action action;
        logic    stack_empty;
        logic    heap_full;
        logic    shader;
        logic    range_fits;
        logic    size_zero;
        logic    div_done;
        logic    free_bad;
        logic    out_free;
    } t_stat;

endpackage

`default_nettype wire

### src/dsa_ifaces.sv
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on dsa_pkg for payload types.
`default_nettype none

interface dsa_req_if import dsa_pkg::*; ();
    logic                valid;
    logic                ready;
    t_action             action;
    t_heap               heap_type;
    logic [COUNT_W-1:0]  range_count;
    logic [OFFSET_W-1:0] slot_offset;

    modport source (output valid, action, heap_type, range_count, slot_offset,
                    input ready);
    modport sink   (input valid, action, heap_type, range_count, slot_offset,
                    output ready);
endinterface

interface dsa_rsp_if import dsa_pkg::*; ();
    logic                valid;
    logic                ready;
    t_status             status;
    logic [OFFSET_W-1:0] offset_out;
    logic [SLOT_W-1:0]   slot_index;

    modport source (output valid, status, offset_out, slot_index, input ready);
    modport sink   (input valid, status, offset_out, slot_index, output ready);
endinterface

interface dsa_cfg_if import dsa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/dsa_div.sv
// Iterative restoring divider: 22-bit offset by 11-bit descriptor size,
// two quotient bits per cycle. Depends on dsa_pkg.
`default_nettype none

module dsa_div
    import dsa_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [OFFSET_W-1:0] i_dividend,
    input  wire logic [SIZE_W-1:0]   i_divisor,
    output logic                     o_done,
    output logic [OFFSET_W-1:0]      o_quotient
);
    localparam int REM_W = SIZE_W + 1;
    localparam int CNT_W = $clog2(DIV_ITER + 1);

    logic [REM_W-1:0]    r_rem, n_rem;
    logic [OFFSET_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;

    // Two restoring steps: shift in a dividend bit, subtract when it fits
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            n_rem = {n_rem[REM_W-2:0], n_quo[OFFSET_W-1]};
            n_quo = {n_quo[OFFSET_W-2:0], 1'b0};
            if (n_rem >= {1'b0, i_divisor}) begin
                n_rem    = n_rem - {1'b0, i_divisor};
                n_quo[0] = 1'b1;
            end
        end
    end

    // Iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_ITER);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### src/dsa_ctrl.sv
// Sequencer for the slot allocator: one item at a time through decode,
// stack read, divide, multiply and result hand-off. Depends on dsa_pkg.
`default_nettype none

module dsa_ctrl
    import dsa_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);
    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.action)
                    ACT_ALLOC: begin
                        if (!i_stat.stack_empty) begin
                            o_cmd.pop = 1'b1;
                            n_state   = S_READ;
                        end else if (i_stat.heap_full) begin
                            o_cmd.fail      = 1'b1;
                            o_cmd.fail_code = ST_EXHAUSTED;
                            n_state         = S_RESULT;
                        end else begin
                            o_cmd.bump_one = 1'b1;
                            n_state        = S_MUL;
                        end
                    end
                    ACT_FREE: begin
                        if (i_stat.size_zero) begin
                            o_cmd.fail      = 1'b1;
                            o_cmd.fail_code = ST_BAD_FREE;
                            n_state         = S_RESULT;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_DIV;
                        end
                    end
                    ACT_RANGE: begin
                        if (!i_stat.shader) begin
                            o_cmd.fail      = 1'b1;
                            o_cmd.fail_code = ST_NOT_SHADER;
                            n_state         = S_RESULT;
                        end else if (!i_stat.range_fits) begin
                            o_cmd.fail      = 1'b1;
                            o_cmd.fail_code = ST_EXHAUSTED;
                            n_state         = S_RESULT;
                        end else begin
                            o_cmd.bump_range = 1'b1;
                            n_state          = S_MUL;
                        end
                    end
                    default: begin
                        // undefined action: drop without a result
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.take_read = 1'b1;
                n_state         = S_MUL;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    if (i_stat.free_bad) begin
                        o_cmd.fail      = 1'b1;
                        o_cmd.fail_code = ST_BAD_FREE;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                    n_state = S_RESULT;
                end
            end
            S_MUL: begin
                o_cmd.mult = 1'b1;
                n_state    = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/dsa_dp.sv
// Datapath for the slot allocator: size registers, bump pointers, stack depths,
// free-stack memory, divider, multiplier and output register.
// Depends on dsa_pkg and dsa_div.
`default_nettype none

module dsa_dp
    import dsa_pkg::*;
#(
    parameter int RESOURCE_CAPACITY = 4096,
    parameter int SAMPLER_CAPACITY  = 2048,
    parameter int TARGET_CAPACITY   = 256,
    parameter int DEPTH_CAPACITY    = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_req                 i_req,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [SIZE_W-1:0]    i_cfg_data,
    input  wire t_cmd                 i_cmd,
    output t_stat                     o_stat,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_rsp                      o_rsp
);
    localparam int TOTAL   = RESOURCE_CAPACITY + SAMPLER_CAPACITY
                             + TARGET_CAPACITY + DEPTH_CAPACITY;
    localparam int CAP_MAX01 = (RESOURCE_CAPACITY > SAMPLER_CAPACITY)
                               ? RESOURCE_CAPACITY : SAMPLER_CAPACITY;
    localparam int CAP_MAX23 = (TARGET_CAPACITY > DEPTH_CAPACITY)
                               ? TARGET_CAPACITY : DEPTH_CAPACITY;
    localparam int CAP_MAX = (CAP_MAX01 > CAP_MAX23) ? CAP_MAX01 : CAP_MAX23;
    localparam int CNT_W   = $clog2(CAP_MAX + 1);
    localparam int IDX_W   = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int SUM_W   = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;
    localparam int AW      = $clog2(TOTAL);
    localparam int PROD_W  = IDX_W + SIZE_W;

    localparam logic [CNT_W-1:0] CAP [NUM_HEAPS] = '{
        CNT_W'(RESOURCE_CAPACITY), CNT_W'(SAMPLER_CAPACITY),
        CNT_W'(TARGET_CAPACITY),   CNT_W'(DEPTH_CAPACITY)
    };
    localparam logic [AW-1:0] BASE [NUM_HEAPS] = '{
        AW'(0),
        AW'(RESOURCE_CAPACITY),
        AW'(RESOURCE_CAPACITY + SAMPLER_CAPACITY),
        AW'(RESOURCE_CAPACITY + SAMPLER_CAPACITY + TARGET_CAPACITY)
    };

    // Per-heap state
    logic [SIZE_W-1:0]   r_size      [NUM_HEAPS];
    logic [CNT_W-1:0]    r_next_free [NUM_HEAPS];
    logic [CNT_W-1:0]    r_depth     [NUM_HEAPS];
    logic [SLOT_W-1:0]   r_stack     [TOTAL];
    logic [SLOT_W-1:0]   r_rd_data;

    // Captured item and working result
    t_action             r_action;
    t_heap               r_type;
    logic [COUNT_W-1:0]  r_count;
    logic [OFFSET_W-1:0] r_offset;
    logic [IDX_W-1:0]    r_idx;
    logic [OFFSET_W-1:0] r_prod;
    t_status             r_res_status;

    // Output register
    logic                r_out_valid;
    t_rsp                r_rsp;

    logic [CNT_W-1:0]    cur_nf;
    logic [CNT_W-1:0]    cur_depth;
    logic [CNT_W-1:0]    cur_cap;
    logic [SIZE_W-1:0]   cur_size;
    logic [SUM_W-1:0]    range_end;
    logic [AW-1:0]       mem_addr;
    logic [PROD_W-1:0]   prod_full;
    logic                div_done;
    logic [OFFSET_W-1:0] quotient;

    assign cur_nf    = r_next_free[r_type];
    assign cur_depth = r_depth[r_type];
    assign cur_cap   = CAP[r_type];
    assign cur_size  = r_size[r_type];
    assign range_end = SUM_W'(cur_nf) + SUM_W'(r_count);
    // Pop reads the entry below the depth, push writes at the depth
    assign mem_addr  = BASE[r_type] + AW'(cur_depth) - AW'(i_cmd.pop);
    assign prod_full = PROD_W'(r_idx) * PROD_W'(cur_size);

    dsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_offset),
        .i_divisor  (cur_size),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Status toward the controller
    always_comb begin
        o_stat.action      = r_action;
        o_stat.stack_empty = (cur_depth == '0);
        o_stat.heap_full   = (cur_nf >= cur_cap);
        o_stat.shader      = (r_type == HEAP_RESOURCE) || (r_type == HEAP_SAMPLER);
        o_stat.range_fits  = (range_end <= SUM_W'(cur_cap));
        o_stat.size_zero   = (cur_size == '0);
        o_stat.div_done    = div_done;
        o_stat.free_bad    = (quotient >= OFFSET_W'(cur_cap)) || (cur_depth >= cur_cap);
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    // Size registers, bump pointers and stack depths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int h = 0; h < NUM_HEAPS; h++) begin
                r_size[h]      <= SIZE_RESET;
                r_next_free[h] <= '0;
                r_depth[h]     <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SIZE_RESOURCE: r_size[HEAP_RESOURCE] <= i_cfg_data;
                    CFG_SIZE_SAMPLER:  r_size[HEAP_SAMPLER]  <= i_cfg_data;
                    CFG_SIZE_TARGET:   r_size[HEAP_TARGET]   <= i_cfg_data;
                    CFG_SIZE_DEPTH:    r_size[HEAP_DEPTH]    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.bump_one) begin
                r_next_free[r_type] <= cur_nf + CNT_W'(1);
            end else if (i_cmd.bump_range) begin
                r_next_free[r_type] <= CNT_W'(range_end);
            end
            if (i_cmd.pop) begin
                r_depth[r_type] <= cur_depth - CNT_W'(1);
            end else if (i_cmd.push) begin
                r_depth[r_type] <= cur_depth + CNT_W'(1);
            end
        end
    end

    // Free-stack memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[mem_addr] <= quotient[SLOT_W-1:0];
        end
        if (i_cmd.pop) begin
            r_rd_data <= r_stack[mem_addr];
        end
    end

    // Item capture and result assembly
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_req.action;
            r_type   <= i_req.heap_type;
            r_count  <= i_req.range_count;
            r_offset <= i_req.slot_offset;
        end
        if (i_cmd.bump_one || i_cmd.bump_range) begin
            r_idx <= IDX_W'(cur_nf);
        end else if (i_cmd.take_read) begin
            r_idx <= IDX_W'(r_rd_data);
        end else if (i_cmd.push) begin
            r_idx <= IDX_W'(quotient[SLOT_W-1:0]);
        end else if (i_cmd.fail) begin
            r_idx <= '0;
        end
        if (i_cmd.mult) begin
            r_prod       <= prod_full[OFFSET_W-1:0];
            r_res_status <= ST_OK;
        end else if (i_cmd.push) begin
            r_prod       <= '0;
            r_res_status <= ST_OK;
        end else if (i_cmd.fail) begin
            r_prod       <= '0;
            r_res_status <= i_cmd.fail_code;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_rsp.status     <= r_res_status;
            r_rsp.offset_out <= r_prod;
            r_rsp.slot_index <= r_idx[SLOT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire

### src/descriptor_slot_allocator_unit.sv
// Descriptor slot allocator: four heaps, each with a bump pointer and a LIFO free stack.
// Request, response and configuration channels are valid/ready interfaces.
// Depends on dsa_pkg, dsa_ifaces, dsa_ctrl, dsa_dp and dsa_div.
//
// i_req carries one item: allocate a slot, free a slot by byte offset, or allocate
// a contiguous range on the resource or sampler heap. o_rsp returns one item per
// request with status, byte offset and slot index; action code 3 gives no response.
// i_cfg writes the bytes-per-descriptor register of heap i at index i (always ready);
// write it only while the block is idle.
// Items are handled one at a time. States from acceptance to the next acceptance:
//   decode, result for a failure found at decode (exhausted, non-shader range, zero
//   size); decode, multiply, result for a bump-pointer allocation or range;
//   decode, stack read (registered read), multiply, result for a free-stack pop;
//   decode, radix-4 divide of byte offset into slot index, result for a free.
// The response appears in the same cycle in which the block is ready again.
// The response sits in an output register: the next item is accepted while it waits,
// and the sequencer stalls only when a second result is ready before the first is taken.
// Reset (synchronous, active low) clears bump pointers and stack depths and sets every
// descriptor size to 32; the free-stack memory needs no clearing pass.
`default_nettype none

module descriptor_slot_allocator_unit
    import dsa_pkg::*;
#(
    parameter int RESOURCE_CAPACITY = 4096,
    parameter int SAMPLER_CAPACITY  = 2048,
    parameter int TARGET_CAPACITY   = 256,
    parameter int DEPTH_CAPACITY    = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dsa_req_if.sink   i_req,
    dsa_rsp_if.source o_rsp,
    dsa_cfg_if.sink   i_cfg
);
    t_cmd  cmd;
    t_stat stat;
    t_req  req;
    t_rsp  rsp;
    logic  in_ready;
    logic  out_valid;

    assign req.action      = i_req.action;
    assign req.heap_type   = i_req.heap_type;
    assign req.range_count = i_req.range_count;
    assign req.slot_offset = i_req.slot_offset;
    assign i_req.ready     = in_ready;
    assign i_cfg.ready     = 1'b1;

    dsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dsa_dp #(
        .RESOURCE_CAPACITY (RESOURCE_CAPACITY),
        .SAMPLER_CAPACITY  (SAMPLER_CAPACITY),
        .TARGET_CAPACITY   (TARGET_CAPACITY),
        .DEPTH_CAPACITY    (DEPTH_CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_rsp       (rsp)
    );

    // Drive response channel
    assign o_rsp.valid      = out_valid;
    assign o_rsp.status     = rsp.status;
    assign o_rsp.offset_out = rsp.offset_out;
    assign o_rsp.slot_index = rsp.slot_index;

    // One item in flight: no acceptance in the cycle after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while an item is in flight");

    // A result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!out_valid || o_rsp.ready))
        else $error("output register overwritten before it was taken");

    // Pop only from a non-empty stack
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pop |-> (!stat.stack_empty && stat.action == ACT_ALLOC))
        else $error("pop from an empty free stack");

    // Push only after the divider finished and the index checked out
    a_push_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> (stat.div_done && !stat.free_bad && stat.action == ACT_FREE))
        else $error("push without a valid quotient");

    // Divide only a free with a nonzero size
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> (stat.action == ACT_FREE && !stat.size_zero))
        else $error("divider started for a non-free or zero size");

endmodule

`default_nettype wire
